>>> rtl/gtq_pkg.sv
// Shared types and codes for the grouped team queue.
package gtq_pkg;

  localparam int unsigned MEMBER_W  = 12;
  localparam int unsigned TEAM_IN_W = 6;
  localparam int unsigned ID_SPAN   = 4096;
  localparam int unsigned TEAM_SPAN = 64;

  typedef enum logic [1:0] {
    OP_MAP     = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                  operation;
    logic [MEMBER_W-1:0]  member_id;
    logic [TEAM_IN_W-1:0] team_id;
  } cmd_t;

  typedef struct packed {
    logic [MEMBER_W-1:0] out_member;
    status_t             status;
  } res_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RED_HI,
    FSM_RED_LO,
    FSM_ISSUE,
    FSM_TEAM,
    FSM_SLOT,
    FSM_FINISH
  } fsm_t;

endpackage

>>> rtl/gtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, register read data on re, hold it otherwise
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/grouped_team_queue.sv
// Grouped team queue: membership table, per-team queues and a team-order ring.
//
// Usage: one command beat on cmd (valid/stall) gives exactly one result beat
// on res (valid/stall). map writes a member's team, enqueue appends a member
// behind its team, dequeue returns the head member of the front team, clear
// empties every queue while keeping the membership table.
// One command is worked at a time; cmd_stall is high while it is in flight.
// Map and enqueue first pass the member index reduction steps RED_HI and RED_LO
// when MEMBER_SPACE is below 4096. cmd_stall drops in the same cycle that the
// result register loads. Work follows the chain of dependent registered RAM
// reads: membership or ring entry, then the team pointer entry, then the
// member store slot.
// Reset (rst, synchronous) empties all queues at once through per-team valid
// flags and clears the ring pointers; there is no clearing pass. Membership,
// member store and ring contents are undefined until written.
// If res is stalled with a result still waiting, the block holds in its last
// step and commits no state until the output register is free.
module grouped_team_queue #(
  parameter int unsigned MEMBER_SPACE = 4096,
  parameter int unsigned TEAM_COUNT   = 64,
  parameter int unsigned TEAM_DEPTH   = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  gtq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output gtq_pkg::res_t res
);

  localparam int unsigned MW  = (MEMBER_SPACE > 1) ? $clog2(MEMBER_SPACE) : 1;
  localparam int unsigned TW  = (TEAM_COUNT > 1) ? $clog2(TEAM_COUNT) : 1;
  localparam int unsigned PW  = $clog2(2 * TEAM_DEPTH);
  localparam int unsigned PW1 = PW + 1;
  localparam int unsigned OW  = $clog2(2 * TEAM_COUNT);
  localparam int unsigned DW  = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
  localparam int unsigned SD  = TEAM_COUNT * TEAM_DEPTH;
  localparam int unsigned SW  = (SD > 1) ? $clog2(SD) : 1;
  localparam bit REDUCE = (MEMBER_SPACE < gtq_pkg::ID_SPAN);

  typedef logic [TW-1:0] tmod_tab_t [gtq_pkg::TEAM_SPAN];

  // Team id reduced modulo TEAM_COUNT, worked out at elaboration
  function automatic tmod_tab_t make_tmod();
    tmod_tab_t tab;
    for (int i = 0; i < gtq_pkg::TEAM_SPAN; i++) begin
      tab[i] = TW'(i % TEAM_COUNT);
    end
    return tab;
  endfunction

  localparam tmod_tab_t TEAM_MOD = make_tmod();

  // Six restoring compare-subtract steps of member id modulo MEMBER_SPACE
  function automatic logic [gtq_pkg::MEMBER_W-1:0] red_steps(
    input logic [gtq_pkg::MEMBER_W-1:0] r,
    input int unsigned                  top
  );
    logic [31:0] acc;
    logic [31:0] lim;
    acc = 32'(r);
    for (int k = 0; k < 6; k++) begin
      lim = 32'(MEMBER_SPACE) << (top - 32'(k));
      if (acc >= lim) begin
        acc = acc - lim;
      end
    end
    return acc[gtq_pkg::MEMBER_W-1:0];
  endfunction

  function automatic logic [PW-1:0] tptr_inc(input logic [PW-1:0] p);
    return (p == PW'(2 * TEAM_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [DW-1:0] tptr_slot(input logic [PW-1:0] p);
    return (p >= PW'(TEAM_DEPTH)) ? DW'(p - PW'(TEAM_DEPTH)) : DW'(p);
  endfunction

  function automatic logic [PW:0] tfill(input logic [PW-1:0] hd, input logic [PW-1:0] tl);
    return (tl >= hd) ? ({1'b0, tl} - {1'b0, hd})
                      : ({1'b0, tl} + PW1'(2 * TEAM_DEPTH) - {1'b0, hd});
  endfunction

  function automatic logic [OW-1:0] optr_inc(input logic [OW-1:0] p);
    return (p == OW'(2 * TEAM_COUNT - 1)) ? '0 : p + OW'(1);
  endfunction

  function automatic logic [TW-1:0] optr_slot(input logic [OW-1:0] p);
    return (p >= OW'(TEAM_COUNT)) ? TW'(p - OW'(TEAM_COUNT)) : TW'(p);
  endfunction

  // Control state
  gtq_pkg::fsm_t   state, state_next;
  logic            deq_empty, deq_empty_next;
  logic [TEAM_COUNT-1:0] team_vld;
  logic            vld_set, vld_clear;
  logic [OW-1:0]   order_head, order_head_next;
  logic [OW-1:0]   order_tail, order_tail_next;
  logic            res_load;
  gtq_pkg::res_t   res_next;

  // Held command and working registers
  gtq_pkg::op_t                  op_r;
  logic [gtq_pkg::MEMBER_W-1:0]  member_r;
  logic [gtq_pkg::TEAM_IN_W-1:0] team_in_r;
  logic [gtq_pkg::MEMBER_W-1:0]  red;
  logic [TW-1:0]                 team_r;
  logic                          pv_r;

  // Memory ports
  logic          mem_we, mem_re;
  logic [MW-1:0] midx;
  logic [TW-1:0] mem_rdata;
  logic          ring_we, ring_re;
  logic [TW-1:0] ring_rdata;
  logic          ptr_we, ptr_re;
  logic [2*PW-1:0] ptr_wdata, ptr_rdata;
  logic          store_we, store_re;
  logic [SW-1:0] store_addr;
  logic [DW-1:0] store_slot;
  logic [gtq_pkg::MEMBER_W-1:0] store_rdata;

  logic [TW-1:0] t_sel;
  logic [PW-1:0] head_cur, tail_cur;
  logic          cmd_accept;

  assign cmd_stall  = (state != gtq_pkg::FSM_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign midx       = MW'(red);
  assign t_sel      = (op_r == gtq_pkg::OP_DEQUEUE) ? ring_rdata : mem_rdata;
  assign head_cur   = pv_r ? ptr_rdata[2*PW-1:PW] : '0;
  assign tail_cur   = pv_r ? ptr_rdata[PW-1:0] : '0;
  assign store_slot = (op_r == gtq_pkg::OP_ENQUEUE) ? tptr_slot(tail_cur)
                                                     : tptr_slot(head_cur);
  assign store_addr = SW'(32'(team_r) * TEAM_DEPTH) + SW'(store_slot);

  gtq_ram #(.WIDTH(TW), .DEPTH(MEMBER_SPACE)) u_membership (
    .clk   (clk),
    .we    (mem_we),
    .waddr (midx),
    .wdata (TEAM_MOD[team_in_r]),
    .re    (mem_re),
    .raddr (midx),
    .rdata (mem_rdata)
  );

  gtq_ram #(.WIDTH(TW), .DEPTH(TEAM_COUNT)) u_order_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (optr_slot(order_tail)),
    .wdata (team_r),
    .re    (ring_re),
    .raddr (optr_slot(order_head)),
    .rdata (ring_rdata)
  );

  gtq_ram #(.WIDTH(2 * PW), .DEPTH(TEAM_COUNT)) u_team_ptr (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (team_r),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (t_sel),
    .rdata (ptr_rdata)
  );

  gtq_ram #(.WIDTH(gtq_pkg::MEMBER_W), .DEPTH(SD)) u_member_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_addr),
    .wdata (member_r),
    .re    (store_re),
    .raddr (store_addr),
    .rdata (store_rdata)
  );

  // Sequence one command; only one is in flight, so no access overlaps
  always_comb begin
    state_next      = state;
    deq_empty_next  = deq_empty;
    order_head_next = order_head;
    order_tail_next = order_tail;
    vld_set         = 1'b0;
    vld_clear       = 1'b0;
    res_load        = 1'b0;
    res_next.out_member = '0;
    res_next.status     = gtq_pkg::ST_OK;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    ring_we  = 1'b0;
    ring_re  = 1'b0;
    ptr_we   = 1'b0;
    ptr_re   = 1'b0;
    store_we = 1'b0;
    store_re = 1'b0;
    ptr_wdata = {head_cur, tptr_inc(tail_cur)};
    unique case (state)
      gtq_pkg::FSM_IDLE: begin
        if (cmd_valid) begin
          deq_empty_next = 1'b0;
          if (REDUCE && (cmd.operation == gtq_pkg::OP_MAP ||
                         cmd.operation == gtq_pkg::OP_ENQUEUE)) begin
            state_next = gtq_pkg::FSM_RED_HI;
          end else begin
            state_next = gtq_pkg::FSM_ISSUE;
          end
        end
      end
      gtq_pkg::FSM_RED_HI: begin
        state_next = gtq_pkg::FSM_RED_LO;
      end
      gtq_pkg::FSM_RED_LO: begin
        state_next = gtq_pkg::FSM_ISSUE;
      end
      gtq_pkg::FSM_ISSUE: begin
        unique case (op_r)
          gtq_pkg::OP_ENQUEUE: begin
            mem_re     = 1'b1;
            state_next = gtq_pkg::FSM_TEAM;
          end
          gtq_pkg::OP_DEQUEUE: begin
            if (order_head == order_tail) begin
              deq_empty_next = 1'b1;
              state_next     = gtq_pkg::FSM_FINISH;
            end else begin
              ring_re    = 1'b1;
              state_next = gtq_pkg::FSM_TEAM;
            end
          end
          default: begin
            state_next = gtq_pkg::FSM_FINISH;
          end
        endcase
      end
      gtq_pkg::FSM_TEAM: begin
        ptr_re     = 1'b1;
        state_next = (op_r == gtq_pkg::OP_DEQUEUE) ? gtq_pkg::FSM_SLOT
                                                    : gtq_pkg::FSM_FINISH;
      end
      gtq_pkg::FSM_SLOT: begin
        if (head_cur == tail_cur) begin
          deq_empty_next = 1'b1;
        end else begin
          store_re = 1'b1;
        end
        state_next = gtq_pkg::FSM_FINISH;
      end
      gtq_pkg::FSM_FINISH: begin
        // Commit only when the output register can take the result
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = gtq_pkg::FSM_IDLE;
          unique case (op_r)
            gtq_pkg::OP_MAP: begin
              mem_we = 1'b1;
            end
            gtq_pkg::OP_ENQUEUE: begin
              if (tfill(head_cur, tail_cur) >= PW1'(TEAM_DEPTH)) begin
                res_next.status = gtq_pkg::ST_FULL;
              end else begin
                store_we  = 1'b1;
                ptr_we    = 1'b1;
                vld_set   = 1'b1;
                ptr_wdata = {head_cur, tptr_inc(tail_cur)};
                // Team had no one queued: join the tail of the ring
                if (head_cur == tail_cur) begin
                  ring_we         = 1'b1;
                  order_tail_next = optr_inc(order_tail);
                end
              end
            end
            gtq_pkg::OP_DEQUEUE: begin
              if (deq_empty) begin
                res_next.status = gtq_pkg::ST_EMPTY;
              end else begin
                res_next.out_member = store_rdata;
                ptr_we    = 1'b1;
                vld_set   = 1'b1;
                ptr_wdata = {tptr_inc(head_cur), tail_cur};
                // Team emptied: retire it from the ring
                if (tptr_inc(head_cur) == tail_cur) begin
                  order_head_next = optr_inc(order_head);
                end
              end
            end
            gtq_pkg::OP_CLEAR: begin
              vld_clear       = 1'b1;
              order_head_next = '0;
              order_tail_next = '0;
            end
          endcase
        end
      end
      default: begin
        state_next = gtq_pkg::FSM_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gtq_pkg::FSM_IDLE;
      deq_empty  <= 1'b0;
      team_vld   <= '0;
      order_head <= '0;
      order_tail <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      deq_empty  <= deq_empty_next;
      order_head <= order_head_next;
      order_tail <= order_tail_next;
      if (vld_clear) begin
        team_vld <= '0;
      end else if (vld_set) begin
        team_vld[team_r] <= 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the command beat, reduce the index, latch team
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      op_r      <= cmd.operation;
      member_r  <= cmd.member_id;
      team_in_r <= cmd.team_id;
      red       <= cmd.member_id;
    end else if (state == gtq_pkg::FSM_RED_HI) begin
      red <= red_steps(red, 11);
    end else if (state == gtq_pkg::FSM_RED_LO) begin
      red <= red_steps(red, 5);
    end
    if (state == gtq_pkg::FSM_TEAM) begin
      team_r <= t_sel;
      pv_r   <= team_vld[t_sel];
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

>>> rtl/gtq_checker.sv
// Port-level assertions for the grouped team queue, bound to the top level.
module gtq_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input logic          res_valid,
  input logic          res_stall,
  input gtq_pkg::res_t res
);

  // Reset drops any pending result
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // One command in flight: an accepted beat closes the command side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("command taken while another is in flight");

  // A new result only comes out of work in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_stall))
    else $error("result without a command in flight");

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");

  // Failed operations return no member
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != gtq_pkg::ST_OK) |-> (res.out_member == '0))
    else $error("member returned with a failing status");

endmodule

bind grouped_team_queue gtq_checker u_gtq_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

>>> test/tb_grouped_team_queue.sv
// Self-checking testbench for the grouped team queue: predicts every result and compares it.
module tb_grouped_team_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TEAM_DEPTH = 64;
  localparam int unsigned ITEM_GOAL  = 1700;
  localparam int unsigned CALM_FROM  = 1400;

  // Reference behavior of the team queue, plus the results still owed by the block
  class team_queue_model;
    bit [gtq_pkg::TEAM_IN_W-1:0] team_of [gtq_pkg::ID_SPAN];
    bit [gtq_pkg::MEMBER_W-1:0]  slot [gtq_pkg::TEAM_SPAN][TEAM_DEPTH];
    bit [6:0]                    head [gtq_pkg::TEAM_SPAN];
    bit [6:0]                    tail [gtq_pkg::TEAM_SPAN];
    bit [gtq_pkg::TEAM_IN_W-1:0] ring [gtq_pkg::TEAM_SPAN];
    bit [6:0]                    ring_head;
    bit [6:0]                    ring_tail;
    gtq_pkg::res_t               awaited [$];
    int                          errors;
    int                          served;
    int                          empties;
    int                          drops;
    int                          clears;

    task flag(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Apply one accepted command to the model and queue its result
    function void note_command(gtq_pkg::cmd_t c);
      gtq_pkg::res_t               r;
      bit [gtq_pkg::TEAM_IN_W-1:0] t;
      bit [6:0]                    fill;
      r.out_member = '0;
      r.status     = gtq_pkg::ST_OK;
      case (c.operation)
        gtq_pkg::OP_MAP: begin
          team_of[c.member_id] = c.team_id;
        end
        gtq_pkg::OP_ENQUEUE: begin
          t    = team_of[c.member_id];
          fill = tail[t] - head[t];
          if (fill >= TEAM_DEPTH) begin
            r.status = gtq_pkg::ST_FULL;
            drops++;
          end else begin
            // a team that had no one waiting joins the back of the order ring
            if (fill == 0) begin
              ring[ring_tail[5:0]] = t;
              ring_tail++;
            end
            slot[t][tail[t][5:0]] = c.member_id;
            tail[t]++;
          end
        end
        gtq_pkg::OP_DEQUEUE: begin
          t = ring[ring_head[5:0]];
          if (ring_head == ring_tail || head[t] == tail[t]) begin
            r.status = gtq_pkg::ST_EMPTY;
            empties++;
          end else begin
            r.out_member = slot[t][head[t][5:0]];
            head[t]++;
            // retire the front team once its queue runs dry
            if (head[t] == tail[t]) ring_head++;
            served++;
          end
        end
        default: begin
          foreach (head[i]) begin
            head[i] = '0;
            tail[i] = '0;
          end
          ring_head = '0;
          ring_tail = '0;
          clears++;
        end
      endcase
      awaited.push_back(r);
    endfunction

    // Compare one result beat with the oldest prediction
    task check_result(gtq_pkg::res_t got);
      gtq_pkg::res_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with none pending (member %0d, code %0d)",
                       got.out_member, got.status));
        return;
      end
      want = awaited.pop_front();
      if (got.out_member !== want.out_member)
        flag($sformatf("out_member got %0d want %0d", got.out_member, want.out_member));
      if (got.status !== want.status)
        flag($sformatf("status code got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          res_stall = 1'b0;
  gtq_pkg::cmd_t cmd       = '0;
  logic          cmd_stall;
  logic          res_valid;
  gtq_pkg::res_t res;

  team_queue_model tracker = new();
  bit              idle_on = 1'b1;
  int unsigned     beats_sent;
  bit              is_mapped [gtq_pkg::ID_SPAN];
  logic [gtq_pkg::MEMBER_W-1:0] mapped_ids [$];

  grouped_team_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every result beat the block hands over
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_result(res);
  end

  // Stall the result side in random bursts, with quiet stretches between
  initial begin
    forever begin
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Present one command beat and hold it until accepted
  task send_cmd(gtq_pkg::op_t op, logic [gtq_pkg::MEMBER_W-1:0] member,
                logic [gtq_pkg::TEAM_IN_W-1:0] team);
    gtq_pkg::cmd_t c;
    c.operation = op;
    c.member_id = member;
    c.team_id   = team;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    tracker.note_command(c);
    beats_sent++;
  endtask

  task map_member(logic [gtq_pkg::MEMBER_W-1:0] member, logic [gtq_pkg::TEAM_IN_W-1:0] team);
    if (!is_mapped[member]) begin
      is_mapped[member] = 1'b1;
      mapped_ids.push_back(member);
    end
    send_cmd(gtq_pkg::OP_MAP, member, team);
  endtask

  task send_noise(gtq_pkg::op_t op);
    send_cmd(op, gtq_pkg::MEMBER_W'($urandom), gtq_pkg::TEAM_IN_W'($urandom));
  endtask

  task enqueue_any();
    send_cmd(gtq_pkg::OP_ENQUEUE, mapped_ids[$urandom_range(0, mapped_ids.size() - 1)], '0);
  endtask

  // Drop valid and hold off until every pending result is back
  task drain_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited.size() != 0);
  endtask

  initial begin
    logic [gtq_pkg::MEMBER_W-1:0]  m;
    logic [gtq_pkg::TEAM_IN_W-1:0] t;
    int unsigned                   pick;
    bit                            paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, team ordering, empty dequeue, clear, remap
    map_member(12'd0, 6'd0);
    map_member(12'd4095, 6'd63);
    map_member(12'hAAA, 6'h2A);
    map_member(12'h555, 6'h15);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'hFFF, 6'h3F);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'd0, 6'h3F);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'd4095, 6'd0);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'hAAA, 6'd0);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'h555, 6'd0);
    send_cmd(gtq_pkg::OP_CLEAR, 12'hFFF, 6'h3F);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    map_member(12'd0, 6'd63);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_ENQUEUE, 12'd4095, 6'd0);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    send_cmd(gtq_pkg::OP_DEQUEUE, 12'd0, 6'd0);
    drain_results();

    // Random: mostly mapped enqueues and dequeues, with fill and drain bursts
    while (beats_sent < ITEM_GOAL) begin
      idle_on = (beats_sent < CALM_FROM);
      if (!paused && beats_sent > ITEM_GOAL / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        // push one team past its depth so the overflow drop shows up
        m = gtq_pkg::MEMBER_W'($urandom);
        t = gtq_pkg::TEAM_IN_W'($urandom);
        map_member(m, t);
        repeat (TEAM_DEPTH + $urandom_range(1, 4))
          send_cmd(gtq_pkg::OP_ENQUEUE, m, gtq_pkg::TEAM_IN_W'($urandom));
      end else if (pick < 3) begin
        repeat ($urandom_range(20, 80)) send_noise(gtq_pkg::OP_DEQUEUE);
      end else if (pick < 6) begin
        send_noise(gtq_pkg::OP_CLEAR);
      end else if (pick < 21) begin
        map_member(gtq_pkg::MEMBER_W'($urandom), gtq_pkg::TEAM_IN_W'($urandom));
      end else if (pick < 60) begin
        enqueue_any();
      end else begin
        send_noise(gtq_pkg::OP_DEQUEUE);
      end
    end

    drain_results();
    repeat (16) @(posedge clk);
    $display("ran %0d commands: %0d members served, %0d empty dequeues,", beats_sent,
             tracker.served, tracker.empties);
    $display("%0d enqueues dropped on a full team, %0d clears", tracker.drops, tracker.clears);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Give up if the block stops answering
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
